// ----- sv/pwqtl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwqtl_pkg: shared types and constants
// Operation codes, field widths and the control struct of the sorted chains.
// ----------------------------------------------------------------------------
package pwqtl_pkg;

   localparam int OP_W     = 3;
   localparam int ID_FLD_W = 4;
   localparam int PRIO_FLD_W = 8;
   localparam int DELAY_W  = 32;
   localparam int TIME_W   = 64;
   localparam int REL_W    = 5;
   localparam int US_PER_MS = 1000;
   localparam int PROD_W   = DELAY_W + 10;

   localparam logic [OP_W-1:0] OP_SUBMIT      = 3'd0;
   localparam logic [OP_W-1:0] OP_SCHED_AFTER = 3'd1;
   localparam logic [OP_W-1:0] OP_SCHED_AGAIN = 3'd2;
   localparam logic [OP_W-1:0] OP_CANCEL      = 3'd3;
   localparam logic [OP_W-1:0] OP_RELEASE     = 3'd4;
   localparam logic [OP_W-1:0] OP_TAKE        = 3'd5;
   localparam logic [OP_W-1:0] OP_FINISH      = 3'd6;
   localparam logic [OP_W-1:0] OP_SLEEP       = 3'd7;

   // One command per chain per cycle.
   typedef struct packed {
      logic ins;
      logic pop;
      logic rem;
   } chain_op_type;

   typedef struct packed {
      logic                  acted;
      logic                  run_valid;
      logic [ID_FLD_W-1:0]   run_id;
      logic [REL_W-1:0]      released_count;
      logic                  sleep_ok;
      logic                  wakeup_valid;
      logic [TIME_W-1:0]     wakeup_timeout_us;
   } result_type;

endpackage

// ----- sv/pwqtl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwqtl_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pwqtl_req_if import pwqtl_pkg::*; ;
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       operation;
   logic [ID_FLD_W-1:0]   item_id;
   logic [PRIO_FLD_W-1:0] priority_req;
   logic [DELAY_W-1:0]    delay_ms;
   logic [TIME_W-1:0]     now_us;

   modport source(output valid, operation, item_id, priority_req, delay_ms, now_us,
                  input ready);
   modport sink(input valid, operation, item_id, priority_req, delay_ms, now_us,
                output ready);
endinterface

interface pwqtl_rsp_if import pwqtl_pkg::*; ;
   logic                valid;
   logic                ready;
   logic                acted;
   logic                run_valid;
   logic [ID_FLD_W-1:0] run_id;
   logic [REL_W-1:0]    released_count;
   logic                sleep_ok;
   logic                wakeup_valid;
   logic [TIME_W-1:0]   wakeup_timeout_us;

   modport source(output valid, acted, run_valid, run_id, released_count, sleep_ok,
                  wakeup_valid, wakeup_timeout_us, input ready);
   modport sink(input valid, acted, run_valid, run_id, released_count, sleep_ok,
                wakeup_valid, wakeup_timeout_us, output ready);
endinterface

// ----- sv/priority_work_queue_with_timer_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_work_queue_with_timer_list: ready queue plus timer queue
// Work items kept in a priority-sorted ready chain and a due-time-sorted timer
// chain, driven by one request at a time.
// ----------------------------------------------------------------------------
//
//   channel | dir | transfer when        | carries
//   --------+-----+----------------------+-----------------------------------
//   req     | in  | valid && ready       | operation, item, priority, delay, now
//   rsp     | out | valid && ready       | one result per request
//
// A request passes through capture, the delay-times-1000 multiply, one update
// of the cell chains and the load of the result register before the next
// transfer can happen; its result is offered once the result register is
// loaded. Release of due timers adds one chain update for every item moved,
// since each move pops the timer chain head and inserts it into the ready
// chain, plus a final check that finds the timer head not due.
// Reset is synchronous and empties both chains and all flags; it needs no
// clearing pass. A new request is taken while an older result still waits in
// the result register; the block stalls only when a second result is ready
// before the first has been taken.
module priority_work_queue_with_timer_list import pwqtl_pkg::*; #(
   parameter int NUM_ITEMS     = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  logic          clock,
   input  logic          reset,
   pwqtl_req_if.sink     req_chan,
   pwqtl_rsp_if.source   rsp_chan
);

   localparam int IDW  = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
   localparam int CW   = $clog2(NUM_ITEMS + 1);
   localparam int PB   = PRIORITY_BITS;
   localparam int TE_W = TIME_W + PB;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CALC = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_REL  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff, state_in;

   // Captured request.
   logic [OP_W-1:0]     op_ff;
   logic [ID_FLD_W-1:0] item_ff;
   logic [PB-1:0]       prio_ff;
   logic [DELAY_W-1:0]  delay_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [PROD_W-1:0]   prod_ff;

   // Per-item state. Due times must read as zero before the first schedule.
   logic [NUM_ITEMS-1:0] sub_ff, sub_in;
   logic [NUM_ITEMS-1:0] sch_ff, sch_in;
   logic [NUM_ITEMS-1:0] run_ff, run_in;
   logic [TIME_W-1:0]    due_ff [NUM_ITEMS];
   logic                 due_we;
   logic [TIME_W-1:0]    due_new;

   logic [CW-1:0] cnt_ff, cnt_in;
   result_type    res_ff, res_in;
   result_type    rsp_ff;
   logic          rsp_valid_ff;

   // Chain controls.
   chain_op_type    rdy_op, tmr_op;
   logic [PB-1:0]   rdy_ins_entry;
   logic [IDW-1:0]  rdy_ins_id;
   logic [TE_W-1:0] tmr_ins_entry;
   logic            rdy_head_valid, tmr_head_valid;
   logic [PB-1:0]   rdy_head_entry;
   logic [TE_W-1:0] tmr_head_entry;
   logic [IDW-1:0]  rdy_head_id, tmr_head_id;
   logic [TIME_W-1:0] tmr_head_due;
   logic [PB-1:0]     tmr_head_prio;

   // Field width adaption.
   logic [IDW+ID_FLD_W-1:0] item_wide;
   logic [IDW-1:0]          idx;
   logic                    id_ok;
   logic [PB+PRIO_FLD_W-1:0] prio_wide;
   logic [IDW+ID_FLD_W-1:0] head_wide;
   logic [CW+REL_W-1:0]     cnt_wide;
   logic                    req_ok;
   logic                    done_go;

   assign item_wide = {{IDW{1'b0}}, item_ff};
   assign idx       = item_wide[IDW-1:0];
   assign id_ok     = (32'(item_ff) < NUM_ITEMS);
   assign prio_wide = {{PB{1'b0}}, req_chan.priority_req};
   assign head_wide = {{ID_FLD_W{1'b0}}, rdy_head_id};
   assign cnt_wide  = {{REL_W{1'b0}}, cnt_ff};

   assign tmr_head_due  = tmr_head_entry[TE_W-1 -: TIME_W];
   assign tmr_head_prio = tmr_head_entry[PB-1:0];

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_ok         = req_chan.valid && req_chan.ready;
   assign done_go        = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   pwqtl_chain #(.DEPTH(NUM_ITEMS), .ENTRY_W(PB), .KEY_W(PB), .ID_W(IDW)) u_ready (
      .clock(clock), .reset(reset), .op(rdy_op),
      .ins_entry(rdy_ins_entry), .ins_id(rdy_ins_id), .rem_id(idx),
      .head_valid(rdy_head_valid), .head_entry(rdy_head_entry), .head_id(rdy_head_id)
   );

   pwqtl_chain #(.DEPTH(NUM_ITEMS), .ENTRY_W(TE_W), .KEY_W(TIME_W), .ID_W(IDW)) u_timer (
      .clock(clock), .reset(reset), .op(tmr_op),
      .ins_entry(tmr_ins_entry), .ins_id(idx), .rem_id(idx),
      .head_valid(tmr_head_valid), .head_entry(tmr_head_entry), .head_id(tmr_head_id)
   );

   // Execution of the captured request.
   always_comb begin
      state_in      = state_ff;
      sub_in        = sub_ff;
      sch_in        = sch_ff;
      run_in        = run_ff;
      cnt_in        = cnt_ff;
      res_in        = res_ff;
      rdy_op        = '0;
      tmr_op        = '0;
      rdy_ins_entry = prio_ff;
      rdy_ins_id    = idx;
      due_we        = 1'b0;
      due_new       = ((op_ff == OP_SCHED_AFTER) ? now_ff : due_ff[idx])
                      + TIME_W'(prod_ff);
      tmr_ins_entry = {due_new, prio_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_ok) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            res_in   = '0;
            state_in = S_DONE;
            unique case (op_ff)
               OP_SUBMIT: begin
                  if (id_ok && !sub_ff[idx]) begin
                     // A scheduled item leaves the timer chain first.
                     tmr_op.rem   = sch_ff[idx];
                     sch_in[idx]  = 1'b0;
                     rdy_op.ins   = 1'b1;
                     sub_in[idx]  = 1'b1;
                     res_in.acted = 1'b1;
                  end
               end
               OP_SCHED_AFTER, OP_SCHED_AGAIN: begin
                  if (id_ok && !sub_ff[idx] && !sch_ff[idx]) begin
                     due_we       = 1'b1;
                     tmr_op.ins   = 1'b1;
                     sch_in[idx]  = 1'b1;
                     res_in.acted = 1'b1;
                  end
               end
               OP_CANCEL: begin
                  if (id_ok && sch_ff[idx]) begin
                     tmr_op.rem   = 1'b1;
                     sch_in[idx]  = 1'b0;
                     res_in.acted = 1'b1;
                  end
               end
               OP_RELEASE: begin
                  cnt_in   = '0;
                  state_in = S_REL;
               end
               OP_TAKE: begin
                  if (rdy_head_valid) begin
                     rdy_op.pop            = 1'b1;
                     sub_in[rdy_head_id]   = 1'b0;
                     run_in[rdy_head_id]   = 1'b1;
                     res_in.acted          = 1'b1;
                     res_in.run_valid      = 1'b1;
                     res_in.run_id         = head_wide[ID_FLD_W-1:0];
                  end
               end
               OP_FINISH: begin
                  if (id_ok && run_ff[idx]) begin
                     run_in[idx]  = 1'b0;
                     res_in.acted = 1'b1;
                  end
               end
               OP_SLEEP: begin
                  if (!rdy_head_valid) begin
                     if (!tmr_head_valid) begin
                        res_in.sleep_ok = 1'b1;
                     end else if (tmr_head_due >= now_ff) begin
                        res_in.sleep_ok          = 1'b1;
                        res_in.wakeup_valid      = 1'b1;
                        res_in.wakeup_timeout_us = tmr_head_due - now_ff;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_REL: begin
            // One due item per cycle moves from the timer head to the ready chain.
            if (tmr_head_valid && (tmr_head_due <= now_ff)) begin
               tmr_op.pop          = 1'b1;
               rdy_op.ins          = 1'b1;
               rdy_ins_entry       = tmr_head_prio;
               rdy_ins_id          = tmr_head_id;
               sch_in[tmr_head_id] = 1'b0;
               sub_in[tmr_head_id] = 1'b1;
               cnt_in              = cnt_ff + 1'b1;
            end else begin
               res_in.acted          = (cnt_ff != '0);
               res_in.released_count = cnt_wide[REL_W-1:0];
               state_in              = S_DONE;
            end
         end
         S_DONE: begin
            if (done_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sub_ff       <= '0;
         sch_ff       <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_ITEMS; i++) begin
            due_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         sub_ff   <= sub_in;
         sch_ff   <= sch_in;
         run_ff   <= run_in;
         if (due_we) begin
            due_ff[idx] <= due_new;
         end
         if (done_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_ok) begin
         op_ff    <= req_chan.operation;
         item_ff  <= req_chan.item_id;
         prio_ff  <= prio_wide[PB-1:0];
         delay_ff <= req_chan.delay_ms;
         now_ff   <= req_chan.now_us;
      end
      prod_ff <= PROD_W'(delay_ff) * PROD_W'(US_PER_MS);
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
      if (done_go) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.acted             = rsp_ff.acted;
   assign rsp_chan.run_valid         = rsp_ff.run_valid;
   assign rsp_chan.run_id            = rsp_ff.run_id;
   assign rsp_chan.released_count    = rsp_ff.released_count;
   assign rsp_chan.sleep_ok          = rsp_ff.sleep_ok;
   assign rsp_chan.wakeup_valid      = rsp_ff.wakeup_valid;
   assign rsp_chan.wakeup_timeout_us = rsp_ff.wakeup_timeout_us;

endmodule

// ----- sv/pwqtl_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwqtl_cell: one slot of a sorted chain
// Holds one entry and shifts with its neighbors on insert, pop and removal.
// ----------------------------------------------------------------------------
module pwqtl_cell import pwqtl_pkg::*; #(
   parameter int ENTRY_W = 8,
   parameter int KEY_W   = 8,
   parameter int ID_W    = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  chain_op_type       op,
   input  logic [ENTRY_W-1:0] ins_entry,
   input  logic [ID_W-1:0]    ins_id,
   input  logic [ID_W-1:0]    rem_id,
   input  logic               left_valid,
   input  logic [ENTRY_W-1:0] left_entry,
   input  logic [ID_W-1:0]    left_id,
   input  logic               left_le,
   input  logic               left_hit,
   input  logic               right_valid,
   input  logic [ENTRY_W-1:0] right_entry,
   input  logic [ID_W-1:0]    right_id,
   output logic               valid,
   output logic [ENTRY_W-1:0] entry,
   output logic [ID_W-1:0]    id,
   output logic               le_out,
   output logic               hit_out
);

   logic               valid_ff, valid_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic [ID_W-1:0]    id_ff, id_in;

   // An entry whose key is not above the new key stays ahead of it.
   assign le_out  = valid_ff &&
                    (entry_ff[ENTRY_W-1 -: KEY_W] <= ins_entry[ENTRY_W-1 -: KEY_W]);
   assign hit_out = left_hit || (valid_ff && (id_ff == rem_id));

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      id_in    = id_ff;
      priority if (op.ins) begin
         if (!le_out) begin
            if (left_le) begin
               valid_in = 1'b1;
               entry_in = ins_entry;
               id_in    = ins_id;
            end else begin
               valid_in = left_valid;
               entry_in = left_entry;
               id_in    = left_id;
            end
         end
      end else if (op.pop || (op.rem && hit_out)) begin
         valid_in = right_valid;
         entry_in = right_entry;
         id_in    = right_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
      id_ff    <= id_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;
   assign id    = id_ff;

endmodule

// ----- sv/pwqtl_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwqtl_chain: sorted queue as a row of cells
// Ascending key order, first in first out among equal keys; head is cell 1.
// ----------------------------------------------------------------------------
module pwqtl_chain import pwqtl_pkg::*; #(
   parameter int DEPTH   = 16,
   parameter int ENTRY_W = 8,
   parameter int KEY_W   = 8,
   parameter int ID_W    = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  chain_op_type       op,
   input  logic [ENTRY_W-1:0] ins_entry,
   input  logic [ID_W-1:0]    ins_id,
   input  logic [ID_W-1:0]    rem_id,
   output logic               head_valid,
   output logic [ENTRY_W-1:0] head_entry,
   output logic [ID_W-1:0]    head_id
);

   logic               c_valid [DEPTH+1];
   logic [ENTRY_W-1:0] c_entry [DEPTH+1];
   logic [ID_W-1:0]    c_id    [DEPTH+1];
   logic               c_le    [DEPTH+1];
   logic               c_hit   [DEPTH+1];

   // Index 0 is the virtual left neighbor of the head cell; cells sit at 1..DEPTH.
   assign c_valid[0] = 1'b0;
   assign c_entry[0] = '0;
   assign c_id[0]    = '0;
   assign c_le[0]    = 1'b1;
   assign c_hit[0]   = 1'b0;

   for (genvar i = 1; i <= DEPTH; i++) begin : g_cell
      logic               r_valid;
      logic [ENTRY_W-1:0] r_entry;
      logic [ID_W-1:0]    r_id;
      if (i == DEPTH) begin : g_last
         assign r_valid = 1'b0;
         assign r_entry = '0;
         assign r_id    = '0;
      end else begin : g_mid
         assign r_valid = c_valid[i+1];
         assign r_entry = c_entry[i+1];
         assign r_id    = c_id[i+1];
      end
      pwqtl_cell #(.ENTRY_W(ENTRY_W), .KEY_W(KEY_W), .ID_W(ID_W)) u_cell (
         .clock(clock), .reset(reset), .op(op),
         .ins_entry(ins_entry), .ins_id(ins_id), .rem_id(rem_id),
         .left_valid(c_valid[i-1]), .left_entry(c_entry[i-1]), .left_id(c_id[i-1]),
         .left_le(c_le[i-1]), .left_hit(c_hit[i-1]),
         .right_valid(r_valid), .right_entry(r_entry), .right_id(r_id),
         .valid(c_valid[i]), .entry(c_entry[i]), .id(c_id[i]),
         .le_out(c_le[i]), .hit_out(c_hit[i])
      );
   end

   assign head_valid = c_valid[1];
   assign head_entry = c_entry[1];
   assign head_id    = c_id[1];

endmodule

// ----- sv/pwqtl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwqtl_checker: port-level checks
// Consistency of the response fields and hold of a stalled response.
// ----------------------------------------------------------------------------
module pwqtl_checker import pwqtl_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                acted,
   input logic                run_valid,
   input logic [REL_W-1:0]    released_count,
   input logic                sleep_ok,
   input logic                wakeup_valid
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_run_acted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && run_valid |-> acted && !sleep_ok && (released_count == '0))
      else $error("take result inconsistent");

   a_wake_sleep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && wakeup_valid |-> sleep_ok && !acted)
      else $error("wakeup without sleep");

   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (released_count != '0) |-> acted && !run_valid)
      else $error("release result inconsistent");

endmodule

bind priority_work_queue_with_timer_list pwqtl_checker u_pwqtl_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .acted(rsp_chan.acted),
   .run_valid(rsp_chan.run_valid),
   .released_count(rsp_chan.released_count),
   .sleep_ok(rsp_chan.sleep_ok),
   .wakeup_valid(rsp_chan.wakeup_valid)
);
